FILE: rtl/line_scan_flat_field_correction_top_defines.svh
// Assertion macros for the line-scan flat-field correction block.
`ifndef LINE_SCAN_FLAT_FIELD_CORRECTION_TOP_DEFINES_SVH
`define LINE_SCAN_FLAT_FIELD_CORRECTION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge of clk_i outside reset.
`define LSFFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lsffc assertion failed");
// Check that post holds in the cycle after pre.
`define LSFFC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lsffc assertion failed");
`else
`define LSFFC_ASSERT(lbl, prop)
`define LSFFC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/lsffc_pkg.sv
// Types, constants and stage map of the line-scan flat-field correction block.
package lsffc_pkg;

  // Column store
  localparam int MaxColumns = 8192;
  localparam int AddrW      = $clog2(MaxColumns);

  // Field widths
  localparam int ColW   = 13;
  localparam int PixW   = 8;
  localparam int BandW  = 14;
  localparam int GainW  = 11;
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 24;

  // Gain arithmetic, in thousandths
  localparam int GainUnity  = 1000;
  localparam int GainMax    = 1500;
  localparam int GainMin    = 800;
  localparam int ExcessNum  = 3;
  localparam int ExcessShift = 2;
  // Smallest quotient whose scaled excess runs past GainMax
  localparam int SatQuot = GainUnity + ((GainMax - GainUnity + 1) * 4 + 2) / 3;
  localparam int QuotW   = 11;
  localparam int NumW    = 18;

  // Pixel arithmetic
  localparam int RoundBias = 500;
  localparam int PixMax    = 255;
  localparam int DevW      = 21;
  localparam int MagW      = 19;
  localparam int RcpW      = 20;
  localparam int RcpShift  = 29;
  localparam int RcpMul    = (1 << RcpShift) / GainUnity + 1;
  localparam int QmagW     = MagW + RcpW - RcpShift;
  localparam int SumW      = 12;

  // Register reset values
  localparam int FlatBrightnessRst = 128;
  localparam int ReferenceLevelRst = 128;
  localparam int BandLeftRst       = 0;
  localparam int BandWidthRst      = 8192;
  localparam int WindowStartRst    = 0;
  localparam int WindowEndRst      = 8192;

  // Stage map
  localparam int StIn   = 0;
  localparam int StDiv0 = 1;
  localparam int StQuo  = StDiv0 + QuotW;
  localparam int StMem  = StQuo + 1;
  localparam int StMul  = StMem + 1;
  localparam int StRcp  = StMul + 1;
  localparam int StOut  = StRcp + 1;
  localparam int NumSt  = StOut + 1;

  typedef enum logic {
    ModeLoad  = 1'b0,
    ModePixel = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    RegFlatBrightness = 3'd0,
    RegReferenceLevel = 3'd1,
    RegBandLeft       = 3'd2,
    RegBandWidth      = 3'd3,
    RegWindowStart    = 3'd4,
    RegWindowEnd      = 3'd5
  } reg_e;

  typedef struct packed {
    mode_e                    mode;
    logic [ColW-1:0]          column;
    logic [PixW-1:0]          pixel;
    logic [PixW-1:0]          prof;
    logic                     corr;
    logic                     oob;
    logic [NumW-1:0]          rem;
    logic [QuotW-1:0]         quo;
    logic                     sat;
    logic                     zero;
    logic signed [DevW-1:0]   dev;
    logic                     neg;
    logic [QmagW-1:0]         qmag;
  } pipe_t;

endpackage

FILE: rtl/line_scan_flat_field_correction_top.sv
// Line-scan flat-field correction: config registers, column store and correction pipeline.
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ---------------------------------------
//  s_axis    in   tvalid/tready             tuser mode, tdata column/pixel/profile
//  m_axis    out  tvalid/tready             tuser flags, tdata column/pixel
//  apb       in   psel/penable/pwrite       paddr/pwdata, prdata read back
//
//  One word is taken every cycle unless back pressure has filled every stage. After the
//  input register, a pixel word passes band set-up, 11 divider steps, store read, multiply,
//  reciprocal divide and clamp, each registered, to m_axis; a load word gives no result.
//  Reset clears the registers and the stage valid bits; the column store is not cleared and
//  holds garbage until loaded. Back pressure on m_axis stalls only the stages behind a full
//  stage; bubbles close up and s_axis keeps taking words until every stage holds one.
`include "line_scan_flat_field_correction_top_defines.svh"

module line_scan_flat_field_correction_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lsffc_pkg::CfgAddrW-1:0]       paddr,
  input  logic [lsffc_pkg::CfgDataW-1:0]       pwdata,
  output logic [lsffc_pkg::CfgDataW-1:0]       prdata,
  output logic                                 pready,
  // Input words
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lsffc_pkg::InTdataW-1:0]       s_axis_tdata,  // column, pixel_value,
                                                              // profile_level, zero pad
  input  logic                                 s_axis_tuser,  // mode
  // Result words
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lsffc_pkg::OutTdataW-1:0]      m_axis_tdata,  // out_column, out_pixel,
                                                              // zero pad
  output logic [1:0]                           m_axis_tuser   // was_corrected, out_of_band
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lsffc_pkg::PixW-1:0]  flat_brightness_q;
  logic [lsffc_pkg::PixW-1:0]  reference_level_q;
  logic [lsffc_pkg::ColW-1:0]  band_left_q;
  logic [lsffc_pkg::BandW-1:0] band_width_q;
  logic [lsffc_pkg::BandW-1:0] window_start_q;
  logic [lsffc_pkg::BandW-1:0] window_end_q;
  logic                        cfg_we;
  lsffc_pkg::reg_e             cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_reg = lsffc_pkg::reg_e'(paddr[lsffc_pkg::CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_brightness_q <= lsffc_pkg::PixW'(lsffc_pkg::FlatBrightnessRst);
      reference_level_q <= lsffc_pkg::PixW'(lsffc_pkg::ReferenceLevelRst);
      band_left_q       <= lsffc_pkg::ColW'(lsffc_pkg::BandLeftRst);
      band_width_q      <= lsffc_pkg::BandW'(lsffc_pkg::BandWidthRst);
      window_start_q    <= lsffc_pkg::BandW'(lsffc_pkg::WindowStartRst);
      window_end_q      <= lsffc_pkg::BandW'(lsffc_pkg::WindowEndRst);
    end else if (cfg_we) begin
      case (cfg_reg)
        lsffc_pkg::RegFlatBrightness: flat_brightness_q <= pwdata[lsffc_pkg::PixW-1:0];
        lsffc_pkg::RegReferenceLevel: reference_level_q <= pwdata[lsffc_pkg::PixW-1:0];
        lsffc_pkg::RegBandLeft:       band_left_q       <= pwdata[lsffc_pkg::ColW-1:0];
        lsffc_pkg::RegBandWidth:      band_width_q      <= pwdata[lsffc_pkg::BandW-1:0];
        lsffc_pkg::RegWindowStart:    window_start_q    <= pwdata[lsffc_pkg::BandW-1:0];
        lsffc_pkg::RegWindowEnd:      window_end_q      <= pwdata[lsffc_pkg::BandW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_reg)
      lsffc_pkg::RegFlatBrightness: prdata = lsffc_pkg::CfgDataW'(flat_brightness_q);
      lsffc_pkg::RegReferenceLevel: prdata = lsffc_pkg::CfgDataW'(reference_level_q);
      lsffc_pkg::RegBandLeft:       prdata = lsffc_pkg::CfgDataW'(band_left_q);
      lsffc_pkg::RegBandWidth:      prdata = lsffc_pkg::CfgDataW'(band_width_q);
      lsffc_pkg::RegWindowStart:    prdata = lsffc_pkg::CfgDataW'(window_start_q);
      lsffc_pkg::RegWindowEnd:      prdata = lsffc_pkg::CfgDataW'(window_end_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage registers and flow control
  // ---------------------------------------------------------------------------
  // A stage loads whenever it is empty or its own word moves on; the chain
  // starts at the result register and ends at s_axis_tready.
  logic [lsffc_pkg::NumSt-1:0] vld_q, vld_d, stage_take;
  lsffc_pkg::pipe_t            pl_q [lsffc_pkg::NumSt];
  lsffc_pkg::pipe_t            pl_d [lsffc_pkg::NumSt];

  always_comb begin
    stage_take[lsffc_pkg::StOut] = !vld_q[lsffc_pkg::StOut] || m_axis_tready;
    for (int k = lsffc_pkg::StOut - 1; k >= 0; k--) begin
      stage_take[k] = !vld_q[k] || stage_take[k+1];
    end
  end

  assign s_axis_tready = stage_take[lsffc_pkg::StIn];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < lsffc_pkg::NumSt; k++) begin
        if (stage_take[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < lsffc_pkg::NumSt; k++) begin
      if (stage_take[k]) begin
        pl_q[k] <= pl_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Column store: {gain, profile} per column, one write and one read port
  // ---------------------------------------------------------------------------
  // Loads write and pixels read at the same stage boundary, so every pixel sees
  // all loads accepted before it and none after; no forwarding is needed.
  logic [lsffc_pkg::GainW+lsffc_pkg::PixW-1:0] store_mem [lsffc_pkg::MaxColumns];
  logic [lsffc_pkg::GainW+lsffc_pkg::PixW-1:0] rd_q;
  logic [lsffc_pkg::AddrW-1:0]                 mem_addr;
  logic                                        mem_we, mem_re;
  logic [lsffc_pkg::GainW-1:0]                 gain_new;

  assign mem_addr = lsffc_pkg::AddrW'(pl_q[lsffc_pkg::StQuo].column);
  assign mem_we   = stage_take[lsffc_pkg::StMem] && vld_q[lsffc_pkg::StQuo]
                    && (pl_q[lsffc_pkg::StQuo].mode == lsffc_pkg::ModeLoad)
                    && (32'(pl_q[lsffc_pkg::StQuo].column) < 32'(lsffc_pkg::MaxColumns));
  assign mem_re   = stage_take[lsffc_pkg::StMem] && vld_q[lsffc_pkg::StQuo]
                    && (pl_q[lsffc_pkg::StQuo].mode == lsffc_pkg::ModePixel);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= {gain_new, pl_q[lsffc_pkg::StQuo].prof};
    end
    if (mem_re) begin
      rd_q <= store_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Gain finish: unity for a zero profile, saturate, scale the excess over unity by 3/4, clamp low
  // ---------------------------------------------------------------------------
  logic [lsffc_pkg::QuotW-1:0] quo_fin;
  logic [lsffc_pkg::GainW-1:0] gain_excess;
  logic [lsffc_pkg::GainW:0]   gain_exc3;

  always_comb begin
    quo_fin     = pl_q[lsffc_pkg::StQuo].quo;
    gain_excess = quo_fin - lsffc_pkg::GainW'(lsffc_pkg::GainUnity);
    gain_exc3   = (lsffc_pkg::GainW+1)'(gain_excess)
                  * (lsffc_pkg::GainW+1)'(lsffc_pkg::ExcessNum);
    if (pl_q[lsffc_pkg::StQuo].zero) begin
      gain_new = lsffc_pkg::GainW'(lsffc_pkg::GainUnity);
    end else if (pl_q[lsffc_pkg::StQuo].sat) begin
      gain_new = lsffc_pkg::GainW'(lsffc_pkg::GainMax);
    end else if (quo_fin > lsffc_pkg::GainW'(lsffc_pkg::GainUnity)) begin
      gain_new = lsffc_pkg::GainW'(lsffc_pkg::GainUnity)
                 + lsffc_pkg::GainW'(gain_exc3 >> lsffc_pkg::ExcessShift);
    end else if (quo_fin < lsffc_pkg::GainW'(lsffc_pkg::GainMin)) begin
      gain_new = lsffc_pkg::GainW'(lsffc_pkg::GainMin);
    end else begin
      gain_new = quo_fin;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage logic
  // ---------------------------------------------------------------------------
  logic [lsffc_pkg::BandW-1:0]        abs_col;
  logic                               in_band, in_win;
  logic [lsffc_pkg::NumW-1:0]         num;
  logic [lsffc_pkg::NumW:0]           div_trial [lsffc_pkg::QuotW];
  logic [lsffc_pkg::PixW-1:0]         rd_prof;
  logic [lsffc_pkg::GainW-1:0]        rd_gain;
  logic signed [lsffc_pkg::PixW:0]    diff;
  logic signed [lsffc_pkg::DevW-1:0]  biased;
  logic [lsffc_pkg::MagW-1:0]         mag;
  logic [lsffc_pkg::MagW+lsffc_pkg::RcpW-1:0] rcp_prod;
  logic signed [lsffc_pkg::QmagW:0]   quo_s;
  logic signed [lsffc_pkg::SumW-1:0]  tsum;
  logic [lsffc_pkg::PixW-1:0]         flat_pix;

  assign rd_prof = rd_q[lsffc_pkg::PixW-1:0];
  assign rd_gain = rd_q[lsffc_pkg::GainW+lsffc_pkg::PixW-1:lsffc_pkg::PixW];

  always_comb begin
    // Capture the accepted word
    vld_d[lsffc_pkg::StIn]        = s_axis_tvalid;
    pl_d[lsffc_pkg::StIn]         = '0;
    pl_d[lsffc_pkg::StIn].mode    = lsffc_pkg::mode_e'(s_axis_tuser);
    pl_d[lsffc_pkg::StIn].column  = s_axis_tdata[lsffc_pkg::ColW-1:0];
    pl_d[lsffc_pkg::StIn].pixel   = s_axis_tdata[lsffc_pkg::ColW +: lsffc_pkg::PixW];
    pl_d[lsffc_pkg::StIn].prof    =
      s_axis_tdata[lsffc_pkg::ColW + lsffc_pkg::PixW +: lsffc_pkg::PixW];

    // Band and window decision, divider set-up
    abs_col = lsffc_pkg::BandW'(band_left_q) + lsffc_pkg::BandW'(pl_q[lsffc_pkg::StIn].column);
    in_band = (lsffc_pkg::BandW'(pl_q[lsffc_pkg::StIn].column) < band_width_q)
              && (32'(pl_q[lsffc_pkg::StIn].column) < 32'(lsffc_pkg::MaxColumns));
    in_win  = (abs_col >= window_start_q) && (abs_col < window_end_q);
    num     = lsffc_pkg::NumW'(reference_level_q) * lsffc_pkg::NumW'(lsffc_pkg::GainUnity);
    vld_d[lsffc_pkg::StDiv0]      = vld_q[lsffc_pkg::StIn];
    pl_d[lsffc_pkg::StDiv0]       = pl_q[lsffc_pkg::StIn];
    pl_d[lsffc_pkg::StDiv0].oob   = !in_band;
    pl_d[lsffc_pkg::StDiv0].corr  = in_band && in_win;
    pl_d[lsffc_pkg::StDiv0].rem   = num;
    pl_d[lsffc_pkg::StDiv0].quo   = '0;
    pl_d[lsffc_pkg::StDiv0].zero  = (pl_q[lsffc_pkg::StIn].prof == '0);
    pl_d[lsffc_pkg::StDiv0].sat   =
      ((lsffc_pkg::NumW+1)'(pl_q[lsffc_pkg::StIn].prof)
       * (lsffc_pkg::NumW+1)'(lsffc_pkg::SatQuot))
      <= (lsffc_pkg::NumW+1)'(num);

    // Restoring divider, one quotient bit per stage, most significant first
    for (int j = 0; j < lsffc_pkg::QuotW; j++) begin
      div_trial[j] = (lsffc_pkg::NumW+1)'(pl_q[lsffc_pkg::StDiv0+j].prof)
                     << (lsffc_pkg::QuotW - 1 - j);
      vld_d[lsffc_pkg::StDiv0+j+1] = vld_q[lsffc_pkg::StDiv0+j];
      pl_d[lsffc_pkg::StDiv0+j+1]  = pl_q[lsffc_pkg::StDiv0+j];
      if ({1'b0, pl_q[lsffc_pkg::StDiv0+j].rem} >= div_trial[j]) begin
        pl_d[lsffc_pkg::StDiv0+j+1].rem =
          lsffc_pkg::NumW'({1'b0, pl_q[lsffc_pkg::StDiv0+j].rem} - div_trial[j]);
        pl_d[lsffc_pkg::StDiv0+j+1].quo[lsffc_pkg::QuotW-1-j] = 1'b1;
      end
    end

    // Store access: loads end here, pixels pick up profile and gain
    vld_d[lsffc_pkg::StMem] = vld_q[lsffc_pkg::StQuo]
                              && (pl_q[lsffc_pkg::StQuo].mode == lsffc_pkg::ModePixel);
    pl_d[lsffc_pkg::StMem]  = pl_q[lsffc_pkg::StQuo];

    // Deviation times gain
    diff = $signed({1'b0, pl_q[lsffc_pkg::StMem].pixel}) - $signed({1'b0, rd_prof});
    vld_d[lsffc_pkg::StMul]     = vld_q[lsffc_pkg::StMem];
    pl_d[lsffc_pkg::StMul]      = pl_q[lsffc_pkg::StMem];
    pl_d[lsffc_pkg::StMul].dev  = lsffc_pkg::DevW'(diff)
                                  * lsffc_pkg::DevW'($signed({1'b0, rd_gain}));

    // Round and divide the magnitude by 1000 through the reciprocal
    biased   = pl_q[lsffc_pkg::StMul].dev + lsffc_pkg::DevW'(lsffc_pkg::RoundBias);
    mag      = biased[lsffc_pkg::DevW-1] ? lsffc_pkg::MagW'(-biased) : lsffc_pkg::MagW'(biased);
    rcp_prod = (lsffc_pkg::MagW+lsffc_pkg::RcpW)'(mag)
               * (lsffc_pkg::MagW+lsffc_pkg::RcpW)'(lsffc_pkg::RcpMul);
    vld_d[lsffc_pkg::StRcp]      = vld_q[lsffc_pkg::StMul];
    pl_d[lsffc_pkg::StRcp]       = pl_q[lsffc_pkg::StMul];
    pl_d[lsffc_pkg::StRcp].neg   = biased[lsffc_pkg::DevW-1];
    pl_d[lsffc_pkg::StRcp].qmag  =
      rcp_prod[lsffc_pkg::MagW+lsffc_pkg::RcpW-1:lsffc_pkg::RcpShift];

    // Restore the sign (truncation toward zero), add the target level, clamp
    quo_s = pl_q[lsffc_pkg::StRcp].neg ? -$signed({1'b0, pl_q[lsffc_pkg::StRcp].qmag})
                                       : $signed({1'b0, pl_q[lsffc_pkg::StRcp].qmag});
    tsum  = $signed(lsffc_pkg::SumW'(flat_brightness_q)) + lsffc_pkg::SumW'(quo_s);
    if (tsum < 0) begin
      flat_pix = '0;
    end else if (tsum > lsffc_pkg::SumW'(lsffc_pkg::PixMax)) begin
      flat_pix = lsffc_pkg::PixW'(lsffc_pkg::PixMax);
    end else begin
      flat_pix = tsum[lsffc_pkg::PixW-1:0];
    end
    vld_d[lsffc_pkg::StOut] = vld_q[lsffc_pkg::StRcp];
    pl_d[lsffc_pkg::StOut]  = pl_q[lsffc_pkg::StRcp];
    if (pl_q[lsffc_pkg::StRcp].corr) begin
      pl_d[lsffc_pkg::StOut].pixel = flat_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = vld_q[lsffc_pkg::StOut];
  assign m_axis_tdata  = {{(lsffc_pkg::OutTdataW - lsffc_pkg::ColW - lsffc_pkg::PixW){1'b0}},
                          pl_q[lsffc_pkg::StOut].pixel, pl_q[lsffc_pkg::StOut].column};
  assign m_axis_tuser  = {pl_q[lsffc_pkg::StOut].oob, pl_q[lsffc_pkg::StOut].corr};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted word always lands in the input stage.
  `LSFFC_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, vld_q[lsffc_pkg::StIn])
  // Every stored gain lies within the clamp range.
  `LSFFC_ASSERT(a_gain_range,
                mem_we |-> (gain_new >= lsffc_pkg::GainW'(lsffc_pkg::GainMin))
                           && (gain_new <= lsffc_pkg::GainW'(lsffc_pkg::GainMax)))
  // An out-of-band pixel is never flattened.
  `LSFFC_ASSERT(a_oob_passes, m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[0]))

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the line-scan flat-field correction block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsffc_pkg::*;

  localparam int SettleCycles = 40;    // pipeline depth plus margin, loads leave no result
  localparam int StallLimit   = 2000;  // cycles without any handshake before giving up
  localparam int PhaseWords   = 85;
  localparam int NumPhases    = 12;

  typedef struct packed {
    logic [ColW-1:0] column;
    logic [PixW-1:0] pixel;
    logic            corrected;
    logic            out_of_band;
  } pixel_result_t;

  // Shadow of the block: registers, column stores and the results still owed.
  class flat_field_scoreboard;
    bit [7:0]        flat_brightness;
    bit [7:0]        reference_level;
    bit [12:0]       band_left;
    bit [13:0]       band_width;
    bit [13:0]       window_start;
    bit [13:0]       window_end;
    bit [7:0]        profile_mem [MaxColumns];
    bit [GainW-1:0]  gain_mem [MaxColumns];
    bit              loaded [MaxColumns];
    pixel_result_t   owed_q [$];
    int              errors;

    function new();
      flat_brightness = FlatBrightnessRst;
      reference_level = ReferenceLevelRst;
      band_left       = BandLeftRst;
      band_width      = BandWidthRst;
      window_start    = WindowStartRst;
      window_end      = WindowEndRst;
      errors          = 0;
    endfunction

    function void set_register(reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegFlatBrightness: flat_brightness = value[7:0];
        RegReferenceLevel: reference_level = value[7:0];
        RegBandLeft:       band_left       = value[12:0];
        RegBandWidth:      band_width      = value[13:0];
        RegWindowStart:    window_start    = value[13:0];
        RegWindowEnd:      window_end      = value[13:0];
        default: ;
      endcase
    endfunction

    // Gain in thousandths; excess over unity is cut to three quarters.
    function bit [GainW-1:0] gain_for(bit [7:0] profile);
      int unsigned g;
      if (profile == 0) return GainUnity;
      g = (GainUnity * int'(reference_level)) / int'(profile);
      if (g > GainUnity) g = GainUnity + ((g - GainUnity) * ExcessNum) / (1 << ExcessShift);
      if (g > GainMax) g = GainMax;
      else if (g < GainMin) g = GainMin;
      return g[GainW-1:0];
    endfunction

    // True when a pixel at this column would be flattened, i.e. uses the stored profile and gain.
    function bit reads_store(bit [ColW-1:0] col);
      int unsigned abs_col;
      abs_col = int'(band_left) + int'(col);
      return (col < band_width) && (abs_col >= window_start) && (abs_col < window_end);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_word(mode_e mode, bit [ColW-1:0] col, bit [PixW-1:0] pix,
                            bit [PixW-1:0] prof);
      pixel_result_t r;
      int            dev;
      int            t;
      if (mode == ModeLoad) begin
        profile_mem[col] = prof;
        gain_mem[col]    = gain_for(prof);
        loaded[col]      = 1'b1;
        return;
      end
      r.column      = col;
      r.pixel       = pix;
      r.corrected   = 1'b0;
      r.out_of_band = 1'b0;
      if (col >= band_width) begin
        r.out_of_band = 1'b1;
      end else if (reads_store(col)) begin
        dev = (int'(pix) - int'(profile_mem[col])) * int'(gain_mem[col]);
        t   = int'(flat_brightness) + (dev + RoundBias) / GainUnity;  // truncates toward zero
        if (t < 0) t = 0;
        else if (t > PixMax) t = PixMax;
        r.pixel     = t[PixW-1:0];
        r.corrected = 1'b1;
      end
      owed_q.push_back(r);
    endfunction

    function void check_word(pixel_result_t got);
      pixel_result_t exp_r;
      if (owed_q.size() == 0) begin
        $error("unexpected result word: column %0d pixel %0d", got.column, got.pixel);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.column != exp_r.column) begin
        $error("out_column: expected %0d, got %0d", exp_r.column, got.column);
        errors++;
      end
      if (got.pixel != exp_r.pixel) begin
        $error("out_pixel: expected %0d, got %0d", exp_r.pixel, got.pixel);
        errors++;
      end
      if (got.corrected != exp_r.corrected) begin
        $error("was_corrected: expected %0d, got %0d", exp_r.corrected, got.corrected);
        errors++;
      end
      if (got.out_of_band != exp_r.out_of_band) begin
        $error("out_of_band: expected %0d, got %0d", exp_r.out_of_band, got.out_of_band);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [CfgAddrW-1:0]  paddr         = '0;
  logic [CfgDataW-1:0]  pwdata        = '0;
  logic [CfgDataW-1:0]  prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // column, pixel_value, profile_level, zero pad
  logic                 s_axis_tuser  = 1'b0; // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // out_column, out_pixel, zero pad
  logic [1:0]           m_axis_tuser;        // was_corrected, out_of_band

  flat_field_scoreboard sb;
  int                   src_idle_pct   = 0;
  int                   sink_stall_pct = 0;
  int                   stall_cycles   = 0;
  logic [ColW-1:0]      loaded_cols [$];

  line_scan_flat_field_correction_top i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Throttle the result side.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check every result word taken at this edge.
  always @(posedge clk_i) begin
    pixel_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.column      = m_axis_tdata[ColW-1:0];
      got.pixel       = m_axis_tdata[ColW+PixW-1:ColW];
      got.corrected   = m_axis_tuser[0];
      got.out_of_band = m_axis_tuser[1];
      sb.check_word(got);
    end
  end

  // Give up once no handshake of any kind has happened for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one input word and hold it until taken; leaves tvalid high.
  task automatic push_word(mode_e mode, logic [ColW-1:0] col, logic [PixW-1:0] pix,
                           logic [PixW-1:0] prof);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(InTdataW-ColW-2*PixW){1'b0}}, prof, pix, col};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(mode, col, pix, prof);
  endtask

  // Drop tvalid and wait for every owed result.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Drain, then let in-flight loads reach the store before any register changes.
  task automatic settle();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(int fb, int rl, int bl, int bw, int ws, int we);
    write_reg(RegFlatBrightness, fb);
    write_reg(RegReferenceLevel, rl);
    write_reg(RegBandLeft, bl);
    write_reg(RegBandWidth, bw);
    write_reg(RegWindowStart, ws);
    write_reg(RegWindowEnd, we);
  endtask

  // Loads mixed with a majority of pixels, often on loaded columns; some wide random columns.
  task automatic run_phase(int n);
    mode_e           mode;
    logic [ColW-1:0] col;
    int              span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) wait_results();
      mode = ($urandom_range(99) < 35) ? ModeLoad : ModePixel;
      span = (int'(sb.band_width) + 16 > MaxColumns - 1) ? MaxColumns - 1
                                                          : int'(sb.band_width) + 16;
      if (mode == ModePixel && loaded_cols.size() > 0 && $urandom_range(1) == 1)
        col = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
      else if ($urandom_range(3) == 0)
        col = $urandom_range(MaxColumns - 1);
      else
        col = $urandom_range(span);
      // never flatten against an entry that was never loaded
      if (mode == ModePixel && sb.reads_store(col) && !sb.loaded[col]) mode = ModeLoad;
      if (mode == ModeLoad && !sb.loaded[col]) loaded_cols.push_back(col);
      push_word(mode, col, $urandom_range(255),
                ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255)));
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, profile extremes, clamping and rounding.
    push_word(ModeLoad, 13'd0, 8'd0, 8'd0);        // zero profile gives unity gain
    push_word(ModeLoad, 13'd8191, 8'd0, 8'd255);
    push_word(ModeLoad, 13'd1, 8'd0, 8'd1);        // gain saturates high
    push_word(ModeLoad, 13'd2, 8'd0, 8'd128);
    push_word(ModeLoad, 13'd3, 8'd0, 8'd255);      // gain floors at the minimum
    push_word(ModePixel, 13'd0, 8'd255, 8'd0);     // clamps to full scale
    push_word(ModePixel, 13'd0, 8'd0, 8'd0);
    push_word(ModePixel, 13'd8191, 8'd0, 8'd0);    // clamps to zero
    push_word(ModePixel, 13'd1, 8'd255, 8'd0);
    push_word(ModePixel, 13'd1, 8'd0, 8'd0);
    push_word(ModePixel, 13'd2, 8'd127, 8'd0);     // negative half rounds toward zero
    push_word(ModePixel, 13'd3, 8'd0, 8'd0);
    push_word(ModeLoad, 13'd1, 8'd0, 8'd200);      // reload, then use right behind it
    push_word(ModePixel, 13'd1, 8'd50, 8'd255);
    loaded_cols = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd8191};
    settle();

    // Directed: narrow band and window, edges of both.
    apply_setting(255, 255, 5, 100, 10, 50);
    push_word(ModeLoad, 13'd44, 8'd0, 8'd60);
    push_word(ModeLoad, 13'd5, 8'd0, 8'd250);
    push_word(ModeLoad, 13'd150, 8'd0, 8'd90);     // stored although out of band
    push_word(ModePixel, 13'd44, 8'd255, 8'd0);    // last column inside the window
    push_word(ModePixel, 13'd5, 8'd0, 8'd0);       // first column inside the window
    push_word(ModePixel, 13'd45, 8'd77, 8'd0);     // at window end: passes through
    push_word(ModePixel, 13'd4, 8'd33, 8'd0);      // below window start: passes through
    push_word(ModePixel, 13'd100, 8'd200, 8'd0);   // at band width: flagged
    push_word(ModePixel, 13'd8191, 8'd1, 8'd0);
    loaded_cols.push_back(13'd44);
    loaded_cols.push_back(13'd5);
    loaded_cols.push_back(13'd150);
    settle();

    // Directed: empty window, zero reference level.
    apply_setting(0, 0, 0, 8192, 100, 100);
    push_word(ModeLoad, 13'd7, 8'd0, 8'd10);
    push_word(ModePixel, 13'd7, 8'd99, 8'd0);
    loaded_cols.push_back(13'd7);
    settle();

    // Random phases, cycling through the idle and stall mixes.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      case (ph)
        1: apply_setting(0, 255, 0, 8192, 0, 8192);
        3: apply_setting(255, 0, 8191, 8192, 0, 8192);
        5: apply_setting(128, 1, 0, 0, 0, 8192);        // every pixel out of band
        7: apply_setting(200, 100, 10, 300, 8192, 0);   // window inverted
        9: apply_setting(64, 200, 0, 64, 0, 8192);
        default: begin
          int bl;
          int ws;
          bl = $urandom_range(200);
          ws = bl + $urandom_range(40);
          apply_setting($urandom_range(255), $urandom_range(255), bl,
                        $urandom_range(16, 400), ws, ws + $urandom_range(400));
        end
      endcase
      run_phase(PhaseWords);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lsffc_pkg.sv
rtl/line_scan_flat_field_correction_top.sv
tb/tb.sv
